[hw/rtl/segi_pkg.sv]
// shared constants and types for the segment intersection pipeline
package segi_pkg;

  // default coordinate width and fraction width of the meeting point
  localparam int CoordBitsDef = 16;
  localparam int FracBitsDef  = 8;

  // fixed width of each meeting point coordinate
  localparam int MeetBits = 24;

  // per-request sideband carried alongside the divider
  typedef struct packed {
    logic                rhit;
    logic                vsel;
    logic                neg_x;
    logic                neg_y;
    logic [MeetBits-1:0] vert_x;
    logic [MeetBits-1:0] vert_y;
  } side_t;

endpackage

[hw/rtl/segi_div.sv]
// pipelined restoring divider, one quotient bit per stage, x and y in lockstep
module segi_div #(
  parameter int NW = 64,
  parameter int DW = 36,
  parameter int QW = 25
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [NW-1:0]        num_x,
  input  logic [NW-1:0]        num_y,
  input  logic [DW-1:0]        den,
  input  segi_pkg::side_t      in_side,
  output logic                 out_vld,
  output logic [QW-1:0]        q_x,
  output logic [QW-1:0]        q_y,
  output segi_pkg::side_t      out_side
);

  localparam int RW = NW + DW + QW;

  logic                  vld  [QW+1];
  logic [RW-1:0]         rx   [QW+1];
  logic [RW-1:0]         ry   [QW+1];
  logic [DW-1:0]         dd   [QW+1];
  logic [QW-1:0]         qx   [QW+1];
  logic [QW-1:0]         qy   [QW+1];
  segi_pkg::side_t       sd   [QW+1];

  // stage zero inputs
  assign vld[0] = in_vld;
  assign rx[0]  = RW'(num_x);
  assign ry[0]  = RW'(num_y);
  assign dd[0]  = den;
  assign qx[0]  = '0;
  assign qy[0]  = '0;
  assign sd[0]  = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic [RW-1:0] trial;
    logic          ge_x;
    logic          ge_y;

    // trial subtract of the shifted divisor
    always_comb begin
      trial = RW'(dd[k]) << Bit;
      ge_x  = rx[k] >= trial;
      ge_y  = ry[k] >= trial;
    end

    // valid bit of the stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    // remainder and quotient of the stage
    always_ff @(posedge clk) begin
      if (en) begin
        rx[k+1] <= ge_x ? rx[k] - trial : rx[k];
        ry[k+1] <= ge_y ? ry[k] - trial : ry[k];
        dd[k+1] <= dd[k];
        qx[k+1] <= qx[k] | (QW'(ge_x) << Bit);
        qy[k+1] <= qy[k] | (QW'(ge_y) << Bit);
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_vld  = vld[QW];
  assign q_x      = qx[QW];
  assign q_y      = qy[QW];
  assign out_side = sd[QW];

endmodule

[hw/rtl/segment_intersection_top.sv]
// top level of the segment intersection pipeline
//
// One request on s_axis carries two segments as eight signed coordinates.
// Every request gives exactly one result on m_axis: a hit flag on tuser and
// the meeting point (FRAC_BITS fractional bits, 8 by default, rounded to
// nearest) on tdata. The point is zero when the segments do not meet.
// From accept to result a request passes eight arithmetic stages, one
// divider stage per quotient bit, and the output register.
// Throughput is one request per cycle while the receiver does not stall;
// each divider stage makes one quotient bit for x and y together.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// drops as soon as the output register is full; nothing is lost or repeated.
// Reset clears all valid bits; the block has no other state and is ready
// for a request in the first cycle after reset.
// Both segments vertical on one x with overlapping y ranges meet at the
// first start x and the first end y. All other parallel segments and point
// segments give no hit.
module segment_intersection_top #(
  parameter int COORD_BITS = segi_pkg::CoordBitsDef,
  parameter int FRAC_BITS  = segi_pkg::FracBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [8*COORD_BITS-1:0] s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // meet_x, meet_y
  output logic [2*segi_pkg::MeetBits-1:0] m_axis_tdata,
  // hit
  output logic                  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int C   = COORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int MB  = segi_pkg::MeetBits;
  localparam int DFW = C + 1;
  localparam int PW  = 2 * DFW;
  localparam int DW  = PW + 1;
  localparam int XW  = DW + DFW + 1;
  localparam int NW  = XW + F + 2;
  localparam int QW  = C + F + 1;
  localparam int VW  = C + F;

  logic en;
  logic vld [8];

  // stage 1: coordinates and differences
  logic signed [C-1:0]   fx0_1, fy0_1, fx1_1, fy1_1, gx0_1, gy0_1, gx1_1, gy1_1;
  logic signed [DFW-1:0] fdx_1, fdy_1, gdx_1, gdy_1, hx_1, hy_1;
  logic signed [C-1:0]   in_c [8];

  // stage 2: flags, bounds and cross products
  logic                  pnt_2, vert_2, vhit_2;
  logic signed [C-1:0]   fx0_2, fy0_2;
  logic signed [C-1:0]   mnfx_2, mxfx_2, mnfy_2, mxfy_2, mngx_2, mxgx_2, mngy_2, mxgy_2;
  logic signed [DFW-1:0] fdx_2, fdy_2;
  logic signed [PW-1:0]  p1_2, p2_2, p3_2, p4_2;
  logic [MB-1:0]         vx_2, vy_2;
  logic signed [VW-1:0]  vxs, vys;

  // stage 3: raw denominator and parameter numerator
  logic                  pnt_3, vert_3, vhit_3;
  logic signed [C-1:0]   fx0_3, fy0_3;
  logic signed [C-1:0]   mnfx_3, mxfx_3, mnfy_3, mxfy_3, mngx_3, mxgx_3, mngy_3, mxgy_3;
  logic signed [DFW-1:0] fdx_3, fdy_3;
  logic signed [DW-1:0]  dr_3, tr_3;
  logic [MB-1:0]         vx_3, vy_3;

  // stage 4: denominator made positive
  logic                  pnt_4, vert_4, vhit_4, dnz_4;
  logic signed [C-1:0]   fx0_4, fy0_4;
  logic signed [C-1:0]   mnfx_4, mxfx_4, mnfy_4, mxfy_4, mngx_4, mxgx_4, mngy_4, mxgy_4;
  logic signed [DFW-1:0] fdx_4, fdy_4;
  logic signed [DW-1:0]  den_4, tn_4;
  logic [MB-1:0]         vx_4, vy_4;

  // stage 5: point and bound products
  logic                  pnt_5, vert_5, vhit_5, dnz_5;
  logic signed [DW-1:0]  den_5;
  logic signed [XW-1:0]  xa_5, xb_5, ya_5, yb_5;
  logic signed [XW-1:0]  lfx_5, hfx_5, lfy_5, hfy_5, lgx_5, hgx_5, lgy_5, hgy_5;
  logic [MB-1:0]         vx_5, vy_5;

  // stage 6: point numerators
  logic                  pnt_6, vert_6, vhit_6, dnz_6;
  logic signed [DW-1:0]  den_6;
  logic signed [XW-1:0]  xn_6, yn_6;
  logic signed [XW-1:0]  lfx_6, hfx_6, lfy_6, hfy_6, lgx_6, hgx_6, lgy_6, hgy_6;
  logic [MB-1:0]         vx_6, vy_6;

  // stage 7: range test and magnitudes
  logic                  rhit_7, vsel_7, negx_7, negy_7;
  logic signed [DW-1:0]  den_7;
  logic [XW-1:0]         magx_7, magy_7;
  logic [MB-1:0]         vx_7, vy_7;
  logic                  inr;

  // stage 8: divider operands
  logic [NW-1:0]         nx_8, ny_8;
  logic [DW:0]           d2_8;
  segi_pkg::side_t       side_8;

  // divider outputs and result
  logic                  dvld;
  logic [QW-1:0]         qx, qy;
  segi_pkg::side_t       dside;
  logic signed [QW:0]    sqx, sqy;
  logic [MB-1:0]         res_x, res_y;
  logic                  res_hit;

  // pipeline advances unless the output register is full and stalled
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack the request
  for (genvar i = 0; i < 8; i++) begin : g_unpack
    assign in_c[i] = s_axis_tdata[i*C +: C];
  end

  // valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_axis_tvalid;
      for (int i = 1; i < 8; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // vertical meeting point in output format
  assign vxs = VW'(fx0_1) <<< F;
  assign vys = VW'(fy1_1) <<< F;

  // range test of the exact point against both boxes
  assign inr = (lfx_6 <= xn_6) && (xn_6 <= hfx_6) && (lfy_6 <= yn_6) && (yn_6 <= hfy_6) &&
               (lgx_6 <= xn_6) && (xn_6 <= hgx_6) && (lgy_6 <= yn_6) && (yn_6 <= hgy_6);

  // arithmetic stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      fx0_1 <= in_c[0]; fy0_1 <= in_c[1]; fx1_1 <= in_c[2]; fy1_1 <= in_c[3];
      gx0_1 <= in_c[4]; gy0_1 <= in_c[5]; gx1_1 <= in_c[6]; gy1_1 <= in_c[7];
      fdx_1 <= DFW'(in_c[2]) - DFW'(in_c[0]);
      fdy_1 <= DFW'(in_c[3]) - DFW'(in_c[1]);
      gdx_1 <= DFW'(in_c[6]) - DFW'(in_c[4]);
      gdy_1 <= DFW'(in_c[7]) - DFW'(in_c[5]);
      hx_1  <= DFW'(in_c[4]) - DFW'(in_c[0]);
      hy_1  <= DFW'(in_c[5]) - DFW'(in_c[1]);
      // stage 2
      pnt_2  <= (fdx_1 == '0 && fdy_1 == '0) || (gdx_1 == '0 && gdy_1 == '0);
      vert_2 <= fdx_1 == '0 && gdx_1 == '0;
      vhit_2 <= (fx0_1 == gx0_1) &&
                !(((fy0_1 < fy1_1) ? fy0_1 : fy1_1) > ((gy0_1 > gy1_1) ? gy0_1 : gy1_1)) &&
                !(((fy0_1 > fy1_1) ? fy0_1 : fy1_1) < ((gy0_1 < gy1_1) ? gy0_1 : gy1_1));
      fx0_2  <= fx0_1;
      fy0_2  <= fy0_1;
      mnfx_2 <= (fx0_1 < fx1_1) ? fx0_1 : fx1_1;
      mxfx_2 <= (fx0_1 < fx1_1) ? fx1_1 : fx0_1;
      mnfy_2 <= (fy0_1 < fy1_1) ? fy0_1 : fy1_1;
      mxfy_2 <= (fy0_1 < fy1_1) ? fy1_1 : fy0_1;
      mngx_2 <= (gx0_1 < gx1_1) ? gx0_1 : gx1_1;
      mxgx_2 <= (gx0_1 < gx1_1) ? gx1_1 : gx0_1;
      mngy_2 <= (gy0_1 < gy1_1) ? gy0_1 : gy1_1;
      mxgy_2 <= (gy0_1 < gy1_1) ? gy1_1 : gy0_1;
      fdx_2  <= fdx_1;
      fdy_2  <= fdy_1;
      p1_2   <= fdx_1 * gdy_1;
      p2_2   <= fdy_1 * gdx_1;
      p3_2   <= hx_1 * gdy_1;
      p4_2   <= hy_1 * gdx_1;
      vx_2   <= MB'(vxs);
      vy_2   <= MB'(vys);
      // stage 3
      pnt_3 <= pnt_2; vert_3 <= vert_2; vhit_3 <= vhit_2;
      fx0_3 <= fx0_2; fy0_3 <= fy0_2;
      mnfx_3 <= mnfx_2; mxfx_3 <= mxfx_2; mnfy_3 <= mnfy_2; mxfy_3 <= mxfy_2;
      mngx_3 <= mngx_2; mxgx_3 <= mxgx_2; mngy_3 <= mngy_2; mxgy_3 <= mxgy_2;
      fdx_3 <= fdx_2; fdy_3 <= fdy_2;
      dr_3  <= DW'(p1_2) - DW'(p2_2);
      tr_3  <= DW'(p3_2) - DW'(p4_2);
      vx_3  <= vx_2; vy_3 <= vy_2;
      // stage 4
      pnt_4 <= pnt_3; vert_4 <= vert_3; vhit_4 <= vhit_3;
      dnz_4 <= dr_3 != '0;
      fx0_4 <= fx0_3; fy0_4 <= fy0_3;
      mnfx_4 <= mnfx_3; mxfx_4 <= mxfx_3; mnfy_4 <= mnfy_3; mxfy_4 <= mxfy_3;
      mngx_4 <= mngx_3; mxgx_4 <= mxgx_3; mngy_4 <= mngy_3; mxgy_4 <= mxgy_3;
      fdx_4 <= fdx_3; fdy_4 <= fdy_3;
      den_4 <= dr_3[DW-1] ? -dr_3 : dr_3;
      tn_4  <= dr_3[DW-1] ? -tr_3 : tr_3;
      vx_4  <= vx_3; vy_4 <= vy_3;
      // stage 5
      pnt_5 <= pnt_4; vert_5 <= vert_4; vhit_5 <= vhit_4; dnz_5 <= dnz_4;
      den_5 <= den_4;
      xa_5  <= fx0_4 * den_4;
      xb_5  <= tn_4 * fdx_4;
      ya_5  <= fy0_4 * den_4;
      yb_5  <= tn_4 * fdy_4;
      lfx_5 <= mnfx_4 * den_4; hfx_5 <= mxfx_4 * den_4;
      lfy_5 <= mnfy_4 * den_4; hfy_5 <= mxfy_4 * den_4;
      lgx_5 <= mngx_4 * den_4; hgx_5 <= mxgx_4 * den_4;
      lgy_5 <= mngy_4 * den_4; hgy_5 <= mxgy_4 * den_4;
      vx_5  <= vx_4; vy_5 <= vy_4;
      // stage 6
      pnt_6 <= pnt_5; vert_6 <= vert_5; vhit_6 <= vhit_5; dnz_6 <= dnz_5;
      den_6 <= den_5;
      xn_6  <= xa_5 + xb_5;
      yn_6  <= ya_5 + yb_5;
      lfx_6 <= lfx_5; hfx_6 <= hfx_5; lfy_6 <= lfy_5; hfy_6 <= hfy_5;
      lgx_6 <= lgx_5; hgx_6 <= hgx_5; lgy_6 <= lgy_5; hgy_6 <= hgy_5;
      vx_6  <= vx_5; vy_6 <= vy_5;
      // stage 7
      rhit_7 <= !pnt_6 && !vert_6 && dnz_6 && inr;
      vsel_7 <= !pnt_6 && vert_6 && vhit_6;
      negx_7 <= xn_6[XW-1];
      negy_7 <= yn_6[XW-1];
      magx_7 <= xn_6[XW-1] ? XW'(-xn_6) : XW'(xn_6);
      magy_7 <= yn_6[XW-1] ? XW'(-yn_6) : XW'(yn_6);
      den_7  <= den_6;
      vx_7   <= vx_6; vy_7 <= vy_6;
      // stage 8
      nx_8 <= (NW'(magx_7) << (F + 1)) + NW'(den_7);
      ny_8 <= (NW'(magy_7) << (F + 1)) + NW'(den_7);
      d2_8 <= {den_7, 1'b0};
      side_8.rhit   <= rhit_7;
      side_8.vsel   <= vsel_7;
      side_8.neg_x  <= negx_7;
      side_8.neg_y  <= negy_7;
      side_8.vert_x <= vx_7;
      side_8.vert_y <= vy_7;
    end
  end

  // rounded quotient, one bit per stage
  segi_div #(
    .NW(NW),
    .DW(DW + 1),
    .QW(QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (vld[7]),
    .num_x    (nx_8),
    .num_y    (ny_8),
    .den      (d2_8),
    .in_side  (side_8),
    .out_vld  (dvld),
    .q_x      (qx),
    .q_y      (qy),
    .out_side (dside)
  );

  // restore signs and choose the result
  always_comb begin
    sqx     = dside.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
    sqy     = dside.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    res_hit = dside.rhit || dside.vsel;
    res_x   = '0;
    res_y   = '0;
    if (dside.rhit) begin
      res_x = MB'(sqx);
      res_y = MB'(sqy);
    end else if (dside.vsel) begin
      res_x = dside.vert_x;
      res_y = dside.vert_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dvld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {res_y, res_x};
      m_axis_tuser <= res_hit;
    end
  end

`ifndef SYNTH
  // the input side takes a request exactly when the output can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  // a miss carries a zero point
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("miss with nonzero point");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");
`endif

endmodule
